@@ sv/ieps_pkg.sv @@
package ieps_pkg;

    // Number of encoders served by the poller.
    localparam int ENCODER_COUNT = 3;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int ENC_W    = 2;
    localparam int ANGLE_W  = 12;
    localparam int ADDR_W   = 7;
    localparam int CHAN_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Fixed bus constants.
    localparam logic [ADDR_W-1:0]   SENSOR_ADDR    = 7'h36;
    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd10;
    localparam logic [ADDR_W-1:0]   DEFAULT_MUX    = 7'd112;

    // Operation codes of an input beat.
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_SEL_DONE  = 3'd1,
        OP_READ_DONE = 3'd2,
        OP_BUS_ERROR = 3'd3,
        OP_QUERY     = 3'd4
    } op_t;

    // Request codes of a result beat.
    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_SELECT = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN0  = 3'd3;

    // Transfer sequencer phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SELECT = 2'd1,
        PH_READ   = 2'd2
    } phase_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]         request;
        logic [ADDR_W-1:0]  bus_address;
        logic [7:0]         select_byte;
        logic [ENC_W-1:0]   target_encoder;
        logic [ANGLE_W-1:0] angle;
        logic               is_online;
        logic               is_fresh;
        logic [TIME_W-1:0]  failures;
        logic [TIME_W-1:0]  updated_at;
        logic               query_ok;
    } result_t;

    // Round-robin successor of an encoder index.
    function automatic logic [ENC_W-1:0] advance(input logic [ENC_W-1:0] idx);
        logic [ENC_W-1:0] nxt;
        if (idx == ENC_W'(ENCODER_COUNT - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + ENC_W'(1);
        end
        return nxt;
    endfunction

endpackage

@@ sv/ieps_core.sv @@
module ieps_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [ieps_pkg::OP_W-1:0]       operation,
    input  logic [ieps_pkg::ENC_W-1:0]      encoder,
    input  logic [7:0]                      rx_high,
    input  logic [7:0]                      rx_low,
    input  logic                            start_refused,
    input  logic                            cfg_write,
    input  logic [ieps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ieps_pkg::CFG_W-1:0]      cfg_data,
    output ieps_pkg::result_t               result
);
    import ieps_pkg::*;

    // Configuration registers.
    logic                  enable_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [ADDR_W-1:0]     mux_reg;
    logic [CHAN_W-1:0]     chan_reg [ENCODER_COUNT];

    // Sequencer state.
    phase_t                phase_reg, phase_next;
    logic [ENC_W-1:0]      next_index_reg, next_index_next;
    logic [ENC_W-1:0]      pending_reg, pending_next;
    logic [TIME_W-1:0]     now_ms_reg, now_ms_next;
    logic [TIME_W-1:0]     due_ms_reg, due_ms_next;

    // Per-encoder records.
    logic [ANGLE_W-1:0]    angle_reg  [ENCODER_COUNT];
    logic [TIME_W-1:0]     errors_reg [ENCODER_COUNT];
    logic [TIME_W-1:0]     time_reg   [ENCODER_COUNT];
    logic                  online_reg [ENCODER_COUNT];
    logic                  fresh_reg  [ENCODER_COUNT];

    // Decoded events of the current beat.
    logic                  is_tick, is_sel, is_read, is_err, is_query;
    logic [TIME_W-1:0]     now_inc, now_eff, due_diff;
    logic                  start_sel, start_read, read_done, fail, finish, query_valid;
    logic [ENC_W-1:0]      fail_idx;

    assign is_tick  = (operation == OP_TICK);
    assign is_sel   = (operation == OP_SEL_DONE);
    assign is_read  = (operation == OP_READ_DONE);
    assign is_err   = (operation == OP_BUS_ERROR);
    assign is_query = (operation == OP_QUERY);

    assign now_inc  = now_ms_reg + TIME_W'(1);
    assign now_eff  = is_tick ? now_inc : now_ms_reg;
    assign due_diff = now_inc - due_ms_reg;

    assign start_sel   = is_tick && enable_reg && (phase_reg == PH_IDLE) && !due_diff[TIME_W-1];
    assign start_read  = is_sel && (phase_reg == PH_SELECT);
    assign read_done   = is_read && (phase_reg == PH_READ);
    assign fail        = ((start_sel || start_read) && start_refused)
                         || (is_err && (phase_reg != PH_IDLE));
    assign finish      = fail || read_done;
    assign fail_idx    = start_sel ? next_index_reg : pending_reg;
    assign query_valid = is_query && ({1'b0, encoder} < (ENC_W + 1)'(ENCODER_COUNT));

    // Next state of the sequencer.
    always_comb
    begin
        phase_next      = phase_reg;
        next_index_next = next_index_reg;
        pending_next    = pending_reg;
        now_ms_next     = now_ms_reg;
        due_ms_next     = due_ms_reg;
        if (accept)
        begin
            now_ms_next = now_eff;
            if (start_sel)
            begin
                pending_next = next_index_reg;
            end
            if (finish)
            begin
                phase_next      = PH_IDLE;
                next_index_next = advance(fail_idx);
                due_ms_next     = now_eff + TIME_W'(period_reg);
            end
            else if (start_sel)
            begin
                phase_next = PH_SELECT;
            end
            else if (start_read)
            begin
                phase_next = PH_READ;
            end
        end
        if (cfg_write && (cfg_index == CFG_ENABLE) && cfg_data[0])
        begin
            due_ms_next = now_ms_reg;
        end
    end

    // Result of the current beat.
    always_comb
    begin
        result = '0;
        if (start_sel)
        begin
            result.request        = REQ_SELECT;
            result.bus_address    = mux_reg;
            result.select_byte    = 8'(1) << chan_reg[next_index_reg];
            result.target_encoder = next_index_reg;
        end
        else if (start_read)
        begin
            result.request        = REQ_READ;
            result.bus_address    = SENSOR_ADDR;
            result.target_encoder = pending_reg;
        end
        else if (is_query)
        begin
            result.target_encoder = encoder;
            if (query_valid)
            begin
                result.angle      = angle_reg[encoder];
                result.is_online  = online_reg[encoder];
                result.is_fresh   = fresh_reg[encoder];
                result.failures   = errors_reg[encoder];
                result.updated_at = time_reg[encoder];
                result.query_ok   = online_reg[encoder];
            end
        end
    end

    // Sequencer and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            next_index_reg <= '0;
            pending_reg    <= '0;
            now_ms_reg     <= '0;
            due_ms_reg     <= '0;
            enable_reg     <= 1'b0;
            period_reg     <= DEFAULT_PERIOD;
            mux_reg        <= DEFAULT_MUX;
            for (int i = 0; i < ENCODER_COUNT; i++)
            begin
                chan_reg[i] <= CHAN_W'(i);
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            next_index_reg <= next_index_next;
            pending_reg    <= pending_next;
            now_ms_reg     <= now_ms_next;
            due_ms_reg     <= due_ms_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                if (cfg_index == CFG_PERIOD)
                begin
                    period_reg <= (cfg_data[PERIOD_W-1:0] == '0) ? DEFAULT_PERIOD
                                                                 : cfg_data[PERIOD_W-1:0];
                end
                if (cfg_index == CFG_MUX)
                begin
                    mux_reg <= cfg_data[ADDR_W-1:0];
                end
                for (int i = 0; i < ENCODER_COUNT; i++)
                begin
                    if (cfg_index == CFG_CHAN0 + CFG_IDX_W'(i))
                    begin
                        chan_reg[i] <= cfg_data[CHAN_W-1:0];
                    end
                end
            end
        end
    end

    // Per-encoder records: each lane updates only from its own events.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENCODER_COUNT; i++)
            begin
                angle_reg[i]  <= '0;
                errors_reg[i] <= '0;
                time_reg[i]   <= '0;
                online_reg[i] <= 1'b0;
                fresh_reg[i]  <= 1'b0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < ENCODER_COUNT; i++)
            begin
                if (read_done && (pending_reg == ENC_W'(i)))
                begin
                    angle_reg[i]  <= {rx_high[3:0], rx_low};
                    time_reg[i]   <= now_eff;
                    online_reg[i] <= 1'b1;
                    fresh_reg[i]  <= 1'b1;
                end
                if (fail && (fail_idx == ENC_W'(i)))
                begin
                    errors_reg[i] <= errors_reg[i] + TIME_W'(1);
                    online_reg[i] <= 1'b0;
                    fresh_reg[i]  <= 1'b0;
                end
                if (query_valid && (encoder == ENC_W'(i)))
                begin
                    fresh_reg[i] <= 1'b0;
                end
            end
        end
    end

    // The round-robin pointers never leave the encoder range.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, next_index_reg} < (ENC_W + 1)'(ENCODER_COUNT))
        && ({1'b0, pending_reg} < (ENC_W + 1)'(ENCODER_COUNT)))
        else $error("poll index out of range");

    // An accepted select start moves the sequencer to the select phase.
    a_sel_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (result.request == REQ_SELECT) && !start_refused
        |=> (phase_reg == PH_SELECT))
        else $error("select start did not enter select phase");

    // A read start is only issued from the select phase.
    a_read_from_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (result.request == REQ_READ) |-> (phase_reg == PH_SELECT))
        else $error("read start outside select phase");

    // Every accepted tick advances the millisecond clock by one.
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_tick |=> (now_ms_reg == $past(now_ms_reg) + TIME_W'(1)))
        else $error("tick did not advance time");

endmodule

@@ sv/i2c_encoder_poll_sequencer.sv @@
// Results are registered in the output register, or in the skid entry on a stall.
// Throughput: one input beat per cycle while in_stall is low; each beat is a
// single-pass update of the sequencer and the encoder records, and a two-entry
// output buffer keeps the input side open while one result waits on a stalled output.
// Reset: asynchronous, active low; clears all records and restores register defaults.
module i2c_encoder_poll_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ieps_pkg::OP_W-1:0]       operation,
    input  logic [ieps_pkg::ENC_W-1:0]      encoder,
    input  logic [7:0]                      rx_high,
    input  logic [7:0]                      rx_low,
    input  logic                            start_refused,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      request,
    output logic [ieps_pkg::ADDR_W-1:0]     bus_address,
    output logic [7:0]                      select_byte,
    output logic [ieps_pkg::ENC_W-1:0]      target_encoder,
    output logic [ieps_pkg::ANGLE_W-1:0]    angle,
    output logic                            is_online,
    output logic                            is_fresh,
    output logic [ieps_pkg::TIME_W-1:0]     failures,
    output logic [ieps_pkg::TIME_W-1:0]     updated_at,
    output logic                            query_ok,
    input  logic                            cfg_write,
    input  logic [ieps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ieps_pkg::CFG_W-1:0]      cfg_data
);
    import ieps_pkg::*;

    logic    accept, out_take, out_open;
    result_t result;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    // Input beats are taken whenever the skid entry is free.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_open = !out_valid_reg || out_take;

    ieps_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (operation),
        .encoder       (encoder),
        .rx_high       (rx_high),
        .rx_low        (rx_low),
        .start_refused (start_refused),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result)
    );

    // Output buffer valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge clk)
    begin
        if (out_open)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign request        = out_reg.request;
    assign bus_address    = out_reg.bus_address;
    assign select_byte    = out_reg.select_byte;
    assign target_encoder = out_reg.target_encoder;
    assign angle          = out_reg.angle;
    assign is_online      = out_reg.is_online;
    assign is_fresh       = out_reg.is_fresh;
    assign failures       = out_reg.failures;
    assign updated_at     = out_reg.updated_at;
    assign query_ok       = out_reg.query_ok;

    // The skid entry is only filled behind a held output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output beat");

    // After an accepted beat, the output holds a valid result in the next cycle.
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat lost");

    // A stalled output with a new beat parks that beat in the skid entry.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("beat not parked in skid entry");

endmodule
